FILE: rtl/core/ists_pkg.sv
// Shared types and constants for the time index search block.
`timescale 1ns / 1ps
package ists_pkg;
    localparam int unsigned TimeW = 31;
    localparam int unsigned CountW = 11;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDEND = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_PROBE = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_RREC  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;
endpackage

FILE: rtl/core/interpolation_search_time_index.sv
// Interpolation search over a loaded (time, record) table.
// Sequencing: a load writes its entry on the transfer; a search reads the last entry, checks
// both end entries and, if neither answers it, probes: a multiply, a restoring divide over
// 31 time bits plus 10 index bits, a bound check and a compare for each probe.
// Throughput: one item at a time; a stalled result holds the engine in its output state.
// Synchronous active-low reset clears control; table contents undefined until loaded.
`timescale 1ns / 1ps
module interpolation_search_time_index
    import ists_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [9:0]         i_entry_index,
    input  logic [TimeW-1:0]   i_entry_time,
    input  logic [TimeW-1:0]   i_entry_record,
    input  logic [TimeW-1:0]   i_query_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [TimeW-1:0]   o_found_record,
    output logic [TimeW-1:0]   o_found_time,
    input  logic               i_cfg_we,
    input  logic [CountW-1:0]  i_cfg_data
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned NW = TimeW + AW;      // numerator width
    localparam int unsigned CW = $clog2(NW + 1);

    // table memories
    logic [TimeW-1:0] mem_t [TABLE_DEPTH];
    logic [TimeW-1:0] mem_r [TABLE_DEPTH];
    logic [TimeW-1:0] r_rd_t, r_rd_r;
    logic [AW-1:0]    rd_addr;

    t_state           r_state;
    logic [CountW-1:0] r_count;
    logic [TimeW-1:0] r_q, r_tlo, r_thi;
    logic [AW-1:0]    r_lo, r_hi, r_n;
    logic [NW-1:0]    r_num;
    logic [TimeW:0]   r_rem;
    logic [CW-1:0]    r_bit;
    logic [TimeW-1:0] r_sel_t;
    logic             r_exact;

    logic in_xfer;
    logic out_free;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;

    // saturated last index
    logic [AW-1:0] last_idx;
    always_comb begin
        if (r_count == '0) last_idx = '0;
        else if (32'(r_count) > TABLE_DEPTH) last_idx = AW'(TABLE_DEPTH - 1);
        else last_idx = AW'(r_count - 1'b1);
    end

    // memory ports: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_op == OP_LOAD && 32'(i_entry_index) < TABLE_DEPTH) begin
            mem_t[AW'(i_entry_index)] <= i_entry_time;
            mem_r[AW'(i_entry_index)] <= i_entry_record;
        end
        r_rd_t <= mem_t[rd_addr];
        r_rd_r <= mem_r[rd_addr];
    end

    // probe address is held until the record leaves
    always_comb begin
        unique case (r_state)
            S_RDEND: rd_addr = last_idx;
            S_PROBE, S_CMP, S_RREC, S_OUT: rd_addr = r_n;
            default: rd_addr = '0;
        endcase
    end

    // divider step: restoring, one quotient bit per cycle
    logic [TimeW+1:0] trial;
    assign trial = {r_rem, r_num[NW-1]} - {2'b0, r_thi - r_tlo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CountW'(1);
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_data;
            // result valid: set on a new result, cleared on a transfer
            if (r_state == S_OUT && out_free) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_xfer && i_op == OP_SEARCH) begin
                    r_q <= i_query_time;
                    r_lo <= '0;
                    r_hi <= last_idx;
                    r_state <= S_RDEND;
                end
                S_RDEND: begin
                    // r_rd_t holds entry 0 now
                    r_tlo <= r_rd_t;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_thi <= r_rd_t;
                    r_exact <= 1'b0;
                    if (r_tlo >= r_q) begin
                        r_n <= '0; r_sel_t <= r_tlo; r_state <= S_RREC;
                    end else if (r_rd_t <= r_q) begin
                        r_n <= r_hi; r_sel_t <= r_rd_t; r_state <= S_RREC;
                    end else r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num <= NW'((r_q - r_tlo) * (r_hi - r_lo));
                    r_rem <= '0;
                    r_bit <= CW'(NW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!trial[TimeW+1]) r_rem <= trial[TimeW:0];
                    else r_rem <= {r_rem[TimeW-1:0], r_num[NW-1]};
                    r_num <= {r_num[NW-2:0], !trial[TimeW+1]};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == CW'(1)) begin
                        // quotient < hi-lo so fits AW
                        r_n <= r_lo + AW'({r_num[NW-2:0], !trial[TimeW+1]});
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_n == r_lo) begin
                        r_sel_t <= r_tlo; r_state <= S_RREC;
                    end else if (r_n == r_hi) begin
                        r_sel_t <= r_thi; r_state <= S_RREC;
                    end else r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rd_t < r_q) begin
                        r_lo <= r_n; r_tlo <= r_rd_t; r_state <= S_MUL;
                    end else if (r_rd_t == r_q) begin
                        r_sel_t <= r_q; r_exact <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_hi <= r_n; r_thi <= r_rd_t; r_state <= S_MUL;
                    end
                end
                S_RREC: r_state <= S_OUT;
                S_OUT: if (out_free) begin
                    o_found_record <= r_rd_r;
                    o_found_time <= r_sel_t;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // bounds stay ordered during probing
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo < r_hi && r_n >= r_lo && r_n <= r_hi))
        else $error("probe outside bounds");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("result not presented");
    a_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_exact) |-> (r_sel_t == r_q))
        else $error("exact match time mismatch");
endmodule
